>>> hw/rtl/utf8_stream_decoder_assert.svh
// Assertion macros for the UTF-8 stream decoder.
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define U8SD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("utf8_stream_decoder: check failed");

// next-cycle implication
`define U8SD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("utf8_stream_decoder: check failed");

`else

`define U8SD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define U8SD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> hw/rtl/u8sd_pkg.sv
package u8sd_pkg;

	localparam int CP_W        = 21;
	localparam int LEN_W       = 3;
	localparam int MAX_RESULTS = 4;

	typedef enum logic [7:0] {
		PH_START = 8'b0000_0001,
		PH_LAST  = 8'b0000_0010,
		PH_3E0   = 8'b0000_0100,
		PH_3MID  = 8'b0000_1000,
		PH_3ED   = 8'b0001_0000,
		PH_4F0   = 8'b0010_0000,
		PH_4MID  = 8'b0100_0000,
		PH_4F4   = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		logic [CP_W-1:0]  cp;
		logic [LEN_W-1:0] len;
	} ent_t;

	// all results caused by one input byte
	typedef struct packed {
		logic [2:0]                  cnt;
		ent_t [MAX_RESULTS-1:0]      ent;
	} rec_t;

endpackage

>>> hw/rtl/u8sd_if.sv
interface u8sd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

interface u8sd_cp_if;
	logic        valid;
	logic        ready;
	logic [20:0] code_point;
	logic [2:0]  seq_length;
	logic        last_of_run;

	modport source (output valid, output code_point, output seq_length, output last_of_run,
		input ready);
	modport sink   (input valid, input code_point, input seq_length, input last_of_run,
		output ready);
endinterface

>>> hw/rtl/utf8_stream_decoder.sv
// Path: an accepted byte's results are written into the queue, then the output register.
// Throughput: one byte per cycle while the queue is not full; one result per cycle leaves the
// output register unless decoded.ready stalls it; the queue buffers the extra results.
// Reset: arst_n asynchronously clears decode phase, held count, queue pointers and count,
// result index and output valid; no clearing pass, the block takes bytes right after reset.
module utf8_stream_decoder #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	u8sd_byte_if.sink   raw,
	u8sd_cp_if.source   decoded
);

	logic           push, full, pop, empty;
	u8sd_pkg::rec_t rec, head;

	u8sd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.raw    (raw),
		.push   (push),
		.rec    (rec),
		.q_full (full)
	);

	u8sd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_rec (rec),
		.full   (full),
		.pop    (pop),
		.empty  (empty),
		.head   (head)
	);

	u8sd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.empty   (empty),
		.head    (head),
		.pop     (pop),
		.decoded (decoded)
	);

endmodule

>>> hw/rtl/u8sd_front.sv
`include "utf8_stream_decoder_assert.svh"

module u8sd_front (
	input  logic            clk,
	input  logic            arst_n,
	u8sd_byte_if.sink       raw,
	output logic            push,
	output u8sd_pkg::rec_t  rec,
	input  logic            q_full
);

	u8sd_pkg::phase_t phase_q, op_ph, nx_ph;
	logic [1:0]       held_cnt_q;
	logic [7:0]       held_q [2];
	logic [20:0]      pv_q, pv_new, op_val;
	logic [7:0]       lead_q;
	logic [2:0]       len_q, op_len, k;
	logic [7:0]       b, lo, hi;
	logic             accept, in_rng, fb, tl_emit;
	u8sd_pkg::ent_t   tl;

	assign b         = raw.data_byte;
	assign raw.ready = !q_full;
	assign accept    = raw.valid && raw.ready;
	assign pv_new    = {pv_q[14:0], b[5:0]};

	// continuation window per phase
	always_comb begin
		lo    = 8'hFF;
		hi    = 8'h00;
		nx_ph = u8sd_pkg::PH_START;
		case (phase_q)
			u8sd_pkg::PH_LAST: begin lo = 8'h80; hi = 8'hBF; nx_ph = u8sd_pkg::PH_START; end
			u8sd_pkg::PH_3E0:  begin lo = 8'hA0; hi = 8'hBF; nx_ph = u8sd_pkg::PH_LAST;  end
			u8sd_pkg::PH_3MID: begin lo = 8'h80; hi = 8'hBF; nx_ph = u8sd_pkg::PH_LAST;  end
			u8sd_pkg::PH_3ED:  begin lo = 8'h80; hi = 8'h9F; nx_ph = u8sd_pkg::PH_LAST;  end
			u8sd_pkg::PH_4F0:  begin lo = 8'h90; hi = 8'hBF; nx_ph = u8sd_pkg::PH_3MID;  end
			u8sd_pkg::PH_4MID: begin lo = 8'h80; hi = 8'hBF; nx_ph = u8sd_pkg::PH_3MID;  end
			u8sd_pkg::PH_4F4:  begin lo = 8'h80; hi = 8'h8F; nx_ph = u8sd_pkg::PH_3MID;  end
			default: begin lo = 8'hFF; hi = 8'h00; nx_ph = u8sd_pkg::PH_START; end
		endcase
	end

	assign in_rng = (phase_q != u8sd_pkg::PH_START) && (b >= lo) && (b <= hi);
	assign fb     = (phase_q != u8sd_pkg::PH_START) && !in_rng;
	assign k      = fb ? (3'd1 + {1'b0, held_cnt_q}) : 3'd0;

	// lead byte classification
	always_comb begin
		tl_emit = 1'b0;
		tl.cp   = {13'd0, b};
		tl.len  = 3'd1;
		op_val  = '0;
		op_len  = 3'd0;
		op_ph   = u8sd_pkg::PH_START;
		case (b) inside
			[8'h00:8'hC1]: begin
				tl_emit = 1'b1;
				tl.len  = (b != 8'h00) ? 3'd1 : 3'd0;
			end
			[8'hC2:8'hDF]: begin
				op_val = {16'd0, b[4:0]}; op_len = 3'd2; op_ph = u8sd_pkg::PH_LAST;
			end
			8'hE0: begin
				op_val = {17'd0, b[3:0]}; op_len = 3'd3; op_ph = u8sd_pkg::PH_3E0;
			end
			[8'hE1:8'hEC], 8'hEE, 8'hEF: begin
				op_val = {17'd0, b[3:0]}; op_len = 3'd3; op_ph = u8sd_pkg::PH_3MID;
			end
			8'hED: begin
				op_val = {17'd0, b[3:0]}; op_len = 3'd3; op_ph = u8sd_pkg::PH_3ED;
			end
			8'hF0: begin
				op_val = {18'd0, b[2:0]}; op_len = 3'd4; op_ph = u8sd_pkg::PH_4F0;
			end
			[8'hF1:8'hF3]: begin
				op_val = {18'd0, b[2:0]}; op_len = 3'd4; op_ph = u8sd_pkg::PH_4MID;
			end
			8'hF4: begin
				op_val = {18'd0, b[2:0]}; op_len = 3'd4; op_ph = u8sd_pkg::PH_4F4;
			end
			default: tl_emit = 1'b1;
		endcase
	end

	// result record for this beat
	always_comb begin
		rec.ent[0].cp  = {13'd0, lead_q};
		rec.ent[0].len = 3'd1;
		rec.ent[1].cp  = {13'd0, held_q[0]};
		rec.ent[1].len = 3'd1;
		rec.ent[2].cp  = {13'd0, held_q[1]};
		rec.ent[2].len = 3'd1;
		rec.ent[3]     = '0;
		for (int i = 0; i < u8sd_pkg::MAX_RESULTS; i++) begin
			if (tl_emit && (k == 3'(i)))
				rec.ent[i] = tl;
		end
		if (in_rng) begin
			rec.cnt        = (phase_q == u8sd_pkg::PH_LAST) ? 3'd1 : 3'd0;
			rec.ent[0].cp  = pv_new;
			rec.ent[0].len = len_q;
		end else begin
			rec.cnt = k + {2'b00, tl_emit};
		end
	end

	assign push = accept && (rec.cnt != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= u8sd_pkg::PH_START;
			held_cnt_q <= 2'd0;
		end else if (accept) begin
			if (in_rng) begin
				phase_q <= nx_ph;
				if (phase_q == u8sd_pkg::PH_LAST)
					held_cnt_q <= 2'd0;
				else if (held_cnt_q != 2'd2)
					held_cnt_q <= held_cnt_q + 2'd1;
			end else begin
				held_cnt_q <= 2'd0;
				phase_q    <= tl_emit ? u8sd_pkg::PH_START : op_ph;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (in_rng) begin
				pv_q <= pv_new;
				if (phase_q != u8sd_pkg::PH_LAST && held_cnt_q != 2'd2)
					held_q[held_cnt_q[0]] <= b;
			end else if (!tl_emit) begin
				lead_q <= b;
				pv_q   <= op_val;
				len_q  <= op_len;
			end
		end
	end

	`U8SD_ASSERT_IMP(a_held_open, clk, arst_n, held_cnt_q != 2'd0, phase_q != u8sd_pkg::PH_START)

endmodule

>>> hw/rtl/u8sd_queue.sv
`include "utf8_stream_decoder_assert.svh"

module u8sd_queue #(
	parameter int DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  u8sd_pkg::rec_t  wr_rec,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output u8sd_pkg::rec_t  head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	u8sd_pkg::rec_t  mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_rec;
	end

	`U8SD_ASSERT_IMP(a_no_underrun, clk, arst_n, pop, count_q != '0)
	`U8SD_ASSERT_NXT(a_count_up, clk, arst_n, push && !pop, count_q == $past(count_q) + 1'b1)

endmodule

>>> hw/rtl/u8sd_back.sv
`include "utf8_stream_decoder_assert.svh"

module u8sd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            empty,
	input  u8sd_pkg::rec_t  head,
	output logic            pop,
	u8sd_cp_if.source       decoded
);

	logic [1:0]  idx_q;
	logic        valid_q, last_q, load, is_last;
	logic [20:0] cp_q;
	logic [2:0]  len_q;

	assign load    = !empty && (!valid_q || decoded.ready);
	assign is_last = (({1'b0, idx_q} + 3'd1) == head.cnt);
	assign pop     = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else begin
			if (load)
				valid_q <= 1'b1;
			else if (decoded.ready)
				valid_q <= 1'b0;
			if (load)
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cp_q   <= head.ent[idx_q].cp;
			len_q  <= head.ent[idx_q].len;
			last_q <= is_last;
		end
	end

	assign decoded.valid       = valid_q;
	assign decoded.code_point  = cp_q;
	assign decoded.seq_length  = len_q;
	assign decoded.last_of_run = last_q;

	`U8SD_ASSERT_IMP(a_term_alone, clk, arst_n, valid_q && len_q == 3'd0, cp_q == '0 && last_q)
	`U8SD_ASSERT_IMP(a_multi_last, clk, arst_n, valid_q && len_q > 3'd1, last_q)

endmodule
